// ===== src/fcl_pkg.sv =====
// Shared constants and types for the framed command link.
// Used by fcl_emitter and framed_command_link_with_retransmit; no dependencies.
`timescale 1ns / 1ps

package fcl_pkg;

	// Default parameter values for the top level
	localparam int BUF_DEPTH_DEF = 32;
	localparam int ADC_BITS_DEF  = 12;

	// Timeout register
	localparam int              TIMEOUT_W     = 16;
	localparam logic [15:0]     TIMEOUT_RESET = 16'd3000;

	// Request kinds carried in tuser
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Characters of the protocol
	localparam logic [7:0] CH_START = 8'h21; // '!'
	localparam logic [7:0] CH_END   = 8'h23; // '#'
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Decimal conversion: at most six digits are produced
	localparam int MAX_DIGITS = 6;
	localparam int DIG_CNT_W  = 3;

	// Division by ten as a multiply by a reciprocal; exact for values below 2^16
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	// Message kinds handed from the parser to the emitter
	typedef enum logic [1:0] {
		MSG_CRLF,
		MSG_CRLF_FRAME,
		MSG_FRAME
	} msg_t;

endpackage

// ===== src/framed_command_link_with_retransmit.sv =====
// Top level of the framed command link: command deframer, link state and timeout.
// Depends on fcl_pkg and fcl_emitter.
`timescale 1ns / 1ps

// Accepts one request per cycle (a received byte or a timer tick) whenever the
// message register is free. A request that produces characters leaves a message in
// that register; the emitter takes it when it is idle and then sends one character per
// cycle while m_tready is high: 2 characters for an OK reply, up to 14 for an RST
// reply, up to 12 for a resend. So requests that send nothing flow at one per cycle,
// and the character output sets the rate otherwise.
// The frame's decimal digits are worked out one per cycle during the "!ADC=" prefix.
// The timeout register may be written at any time the link is quiet.
module framed_command_link_with_retransmit import fcl_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int ADC_BITS  = ADC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// rx_byte [7:0], adc_sample [8 +: ADC_BITS], zero padding above
	input  logic [((8 + ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// tx_byte [7:0]
	output logic [7:0]                            m_tdata,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [TIMEOUT_W-1:0]                  cfg_data
);

	localparam int POS_W = $clog2(BUF_DEPTH);

	// Registered state
	logic                  pmode_q;
	logic [POS_W-1:0]      pos_q;
	logic [7:0]            head_q [3];
	logic                  link_q;
	logic [ADC_BITS-1:0]   latched_q;
	logic [TIMEOUT_W-1:0]  cnt_q;
	logic [TIMEOUT_W-1:0]  timeout_q;

	// Message register between parser and emitter
	logic                  msg_valid_s1;
	msg_t                  msg_kind_s1;
	logic [ADC_BITS-1:0]   msg_sample_s1;

	// Next-state logic
	logic                  acc;
	logic [7:0]            rx_b;
	logic [ADC_BITS-1:0]   sample_in;
	logic                  pmode_n;
	logic [POS_W-1:0]      pos_n;
	logic [7:0]            head_n [3];
	logic                  head_we;
	logic [7:0]            head_wd;
	logic                  cmd_end;
	logic                  is_rst;
	logic                  is_ok;
	logic                  link_n;
	logic [ADC_BITS-1:0]   latched_n;
	logic [TIMEOUT_W-1:0]  cnt_n;
	logic [TIMEOUT_W-1:0]  cnt_dec;
	logic                  emit;
	msg_t                  emit_kind;
	logic [ADC_BITS-1:0]   emit_sample;
	logic                  em_idle;
	logic                  take;

	assign acc       = s_tvalid && s_tready;
	assign rx_b      = s_tdata[7:0];
	assign sample_in = s_tdata[8 +: ADC_BITS];
	assign take      = msg_valid_s1 && em_idle;
	assign s_tready  = !msg_valid_s1 || take;
	assign cfg_ready = 1'b1;
	assign cnt_dec   = cnt_q - TIMEOUT_W'(1);

	// Deframer: hunt for the start mark, store the head, stop at the terminator
	always_comb begin
		pmode_n = pmode_q;
		pos_n   = pos_q;
		cmd_end = 1'b0;
		head_we = 1'b0;
		head_wd = (rx_b == CH_END) ? 8'd0 : rx_b;
		if (!pmode_q) begin
			if (rx_b == CH_START) begin
				pmode_n = 1'b1;
				pos_n   = '0;
			end
		end else if (rx_b == CH_END) begin
			pmode_n = 1'b0;
			head_we = 1'b1;
			cmd_end = 1'b1;
		end else if (rx_b == CH_START) begin
			pos_n = '0;
		end else begin
			head_we = 1'b1;
			pos_n   = (pos_q == POS_W'(BUF_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
		end
		for (int i = 0; i < 3; i++) begin
			head_n[i] = (head_we && pos_q == POS_W'(i)) ? head_wd : head_q[i];
		end
		is_rst = (head_n[0] == CH_R) && (head_n[1] == CH_S) && (head_n[2] == CH_T);
		is_ok  = (head_n[0] == CH_O) && (head_n[1] == CH_K);
	end

	// Link protocol and timeout
	always_comb begin
		link_n      = link_q;
		latched_n   = latched_q;
		cnt_n       = cnt_q;
		emit        = 1'b0;
		emit_kind   = MSG_CRLF;
		emit_sample = latched_q;
		if (s_tuser == REQ_BYTE) begin
			if (cmd_end) begin
				if (!link_q && is_rst) begin
					emit        = 1'b1;
					emit_kind   = MSG_CRLF_FRAME;
					emit_sample = sample_in;
					latched_n   = sample_in;
					link_n      = 1'b1;
					cnt_n       = timeout_q;
				end else if (link_q && is_ok) begin
					emit   = 1'b1;
					link_n = 1'b0;
					cnt_n  = '0;
				end
			end
		end else if (cnt_q != '0) begin
			cnt_n = cnt_dec;
			if (cnt_dec == '0 && link_q) begin
				emit      = 1'b1;
				emit_kind = MSG_FRAME;
				cnt_n     = timeout_q;
			end
		end
	end

	// State update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode_q   <= 1'b0;
			pos_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= 8'd0;
			end
			link_q    <= 1'b0;
			latched_q <= '0;
			cnt_q     <= '0;
		end else if (acc) begin
			if (s_tuser == REQ_BYTE) begin
				pmode_q <= pmode_n;
				pos_q   <= pos_n;
				for (int i = 0; i < 3; i++) begin
					head_q[i] <= head_n[i];
				end
			end
			link_q    <= link_n;
			latched_q <= latched_n;
			cnt_q     <= cnt_n;
		end
	end

	// Message register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_s1  <= 1'b0;
			msg_kind_s1   <= MSG_CRLF;
			msg_sample_s1 <= '0;
		end else if (acc && emit) begin
			msg_valid_s1  <= 1'b1;
			msg_kind_s1   <= emit_kind;
			msg_sample_s1 <= emit_sample;
		end else if (take) begin
			msg_valid_s1 <= 1'b0;
		end
	end

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	fcl_emitter #(
		.ADC_BITS (ADC_BITS)
	) u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take),
		.load_kind   (msg_kind_s1),
		.load_sample (msg_sample_s1),
		.idle        (em_idle),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

`ifndef SYNTH
	// A full message register holds off new requests until the emitter takes it.
	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid_s1 && !em_idle) |-> !s_tready)
		else $error("request accepted with message register full");

	// A stopped counter stays stopped when the link is idle and no RST arrives.
	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(!link_q && cnt_q == '0 && !(acc && emit)) |=> (cnt_q == '0))
		else $error("timeout started without a command");

	// A new message is only produced while the register is free or being emptied.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit) |-> (!msg_valid_s1 || take))
		else $error("message register overwritten");
`endif

endmodule

// ===== src/fcl_emitter.sv =====
// Character emitter for the framed command link: serialises one message at a time
// and converts the latched sample to decimal on the fly. Depends on fcl_pkg.
`timescale 1ns / 1ps

module fcl_emitter import fcl_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  msg_t                load_kind,
	input  logic [ADC_BITS-1:0] load_sample,
	output logic                idle,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);

	localparam int PROD_W = ADC_BITS + DIV10_SHIFT;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CR1,
		PH_LF1,
		PH_PRE,
		PH_DIG,
		PH_HASH,
		PH_CR2,
		PH_LF2
	} phase_t;

	phase_t                phase_q;
	logic                  frame_q;
	logic [2:0]            idx_q;
	logic [ADC_BITS-1:0]   conv_val_q;
	logic                  conv_done_q;
	logic [DIG_CNT_W-1:0]  cnt_q;
	logic [3:0]            dig_q [MAX_DIGITS];

	logic [PROD_W-1:0]     prod;
	logic [ADC_BITS-1:0]   quot;
	logic [ADC_BITS-1:0]   rem_full;
	logic [7:0]            ch;
	logic                  ch_last;
	logic                  ch_ok;
	phase_t                phase_n;
	logic                  out_free;
	logic                  advance;

	// Fixed prefix of the frame, "!ADC="
	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = CH_START;
			3'd1:    c = CH_A;
			3'd2:    c = CH_D;
			3'd3:    c = CH_C;
			default: c = CH_EQ;
		endcase
		return c;
	endfunction

	// One decimal digit per cycle, least significant first
	always_comb begin
		prod     = PROD_W'(conv_val_q) * PROD_W'(DIV10_MUL);
		quot     = prod[DIV10_SHIFT +: ADC_BITS];
		rem_full = conv_val_q - (quot << 3) - (quot << 1);
	end

	assign idle     = (phase_q == PH_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign advance  = out_free && ch_ok;

	// Next character and phase of the message being sent
	always_comb begin
		ch      = CH_CR;
		ch_last = 1'b0;
		ch_ok   = 1'b1;
		phase_n = phase_q;
		case (phase_q)
			PH_IDLE: begin
				ch_ok = 1'b0;
			end
			PH_CR1: begin
				ch      = CH_CR;
				phase_n = PH_LF1;
			end
			PH_LF1: begin
				ch      = CH_LF;
				ch_last = !frame_q;
				phase_n = frame_q ? PH_PRE : PH_IDLE;
			end
			PH_PRE: begin
				ch      = prefix_char(idx_q);
				phase_n = (idx_q == 3'd4) ? PH_DIG : PH_PRE;
			end
			PH_DIG: begin
				ch      = CH_ZERO + {4'b0, dig_q[0]};
				ch_ok   = conv_done_q;
				phase_n = (cnt_q == DIG_CNT_W'(1)) ? PH_HASH : PH_DIG;
			end
			PH_HASH: begin
				ch      = CH_END;
				phase_n = PH_CR2;
			end
			PH_CR2: begin
				ch      = CH_CR;
				phase_n = PH_LF2;
			end
			PH_LF2: begin
				ch      = CH_LF;
				ch_last = 1'b1;
				phase_n = PH_IDLE;
			end
			default: begin
				ch_ok   = 1'b0;
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Sequencer, digit stack and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			frame_q     <= 1'b0;
			idx_q       <= 3'd0;
			conv_val_q  <= '0;
			conv_done_q <= 1'b1;
			cnt_q       <= '0;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dig_q[i] <= 4'd0;
			end
			m_tvalid    <= 1'b0;
			m_tdata     <= 8'd0;
			m_tlast     <= 1'b0;
		end else begin
			// Output register: a new character, or empty once taken
			if (!load && advance) begin
				m_tvalid <= 1'b1;
				m_tdata  <= ch;
				m_tlast  <= ch_last;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (load) begin
				phase_q     <= (load_kind == MSG_FRAME) ? PH_PRE : PH_CR1;
				frame_q     <= (load_kind != MSG_CRLF);
				idx_q       <= 3'd0;
				conv_val_q  <= load_sample;
				conv_done_q <= (load_kind == MSG_CRLF);
				cnt_q       <= '0;
			end else begin
				if (advance) begin
					phase_q  <= phase_n;
					if (phase_q == PH_PRE) begin
						idx_q <= idx_q + 3'd1;
					end
					// Pop the most significant digit
					if (phase_q == PH_DIG) begin
						for (int i = 0; i < MAX_DIGITS - 1; i++) begin
							dig_q[i] <= dig_q[i+1];
						end
						dig_q[MAX_DIGITS-1] <= 4'd0;
						cnt_q <= cnt_q - DIG_CNT_W'(1);
					end
				end
				// Push the next digit while conversion runs
				if (!conv_done_q) begin
					dig_q[0] <= rem_full[3:0];
					for (int i = 1; i < MAX_DIGITS; i++) begin
						dig_q[i] <= dig_q[i-1];
					end
					cnt_q       <= cnt_q + DIG_CNT_W'(1);
					conv_val_q  <= quot;
					conv_done_q <= (quot == '0) || (cnt_q == DIG_CNT_W'(MAX_DIGITS - 1));
				end
			end
		end
	end

`ifndef SYNTH
	// The digit stack never overflows.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIG_CNT_W'(MAX_DIGITS))
		else $error("digit count beyond stack depth");

	// A finished conversion always leaves at least one digit to send.
	a_digits_present: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIG && conv_done_q) |-> (cnt_q != '0))
		else $error("digit phase with empty stack");

	// A loaded message always starts a sequence.
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idle) |=> (phase_q != PH_IDLE))
		else $error("load did not start a message");

	// The sequencer is only loaded when idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> idle)
		else $error("load while a message is in progress");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for framed_command_link_with_retransmit: sends received bytes and
// timer ticks, predicts every transmitted character and checks the output stream in order.
// Depends on fcl_pkg and the RTL of the link; needs no files or arguments.

module testbench;
	import fcl_pkg::*;

	localparam int TDATA_W       = ((8 + ADC_BITS_DEF + 7) / 8) * 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} tx_char_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	// rx_byte [7:0], adc_sample [19:8], zero padding above
	logic [TDATA_W-1:0] s_tdata   = '0;
	// req_type
	logic               s_tuser   = REQ_BYTE;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	// tx_byte [7:0]
	logic [7:0]         m_tdata;
	logic               m_tlast;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [TIMEOUT_W-1:0] cfg_data = '0;

	framed_command_link_with_retransmit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted link state, held at the block's widths.
	logic                 in_command  = 1'b0;
	int unsigned          wr_pos      = 0;
	logic [7:0]           head [3]    = '{8'h00, 8'h00, 8'h00};
	logic                 awaiting_ok = 1'b0;
	logic [11:0]          held_sample = '0;
	logic [TIMEOUT_W-1:0] ticks_left  = '0;
	logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RESET;

	logic [7:0] reply [$];
	tx_char_t   tx_expect [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_token    = 0;
	int hold_done     = 0;
	int hold_left     = 0;
	int items_sent    = 0;
	int chars_checked = 0;
	int rst_replies   = 0;
	int resends       = 0;
	int errors        = 0;
	int cycle_count   = 0;

	// Deframer: returns 1 when a terminator closes a command.
	function bit parse_char(logic [7:0] b);
		if (!in_command) begin
			if (b == CH_START) begin
				in_command = 1'b1;
				wr_pos = 0;
			end
			return 1'b0;
		end
		if (b == CH_END) begin
			in_command = 1'b0;
			if (wr_pos < 3)
				head[wr_pos] = 8'h00;
			return 1'b1;
		end
		if (b == CH_START) begin
			wr_pos = 0;
			return 1'b0;
		end
		if (wr_pos < 3)
			head[wr_pos] = b;
		wr_pos = (wr_pos + 1) % BUF_DEPTH_DEF;
		return 1'b0;
	endfunction

	function void add_crlf();
		reply.push_back(CH_CR);
		reply.push_back(CH_LF);
	endfunction

	// The frame !ADC=<decimal>#CR LF for the held sample.
	function void add_frame();
		logic [7:0]  digit_ch [MAX_DIGITS];
		int          n;
		int unsigned v;
		v = held_sample;
		n = 0;
		do begin
			digit_ch[n] = CH_ZERO + 8'(v % 10);
			v = v / 10;
			n++;
		end while (v != 0 && n < MAX_DIGITS);
		reply.push_back(CH_START);
		reply.push_back(CH_A);
		reply.push_back(CH_D);
		reply.push_back(CH_C);
		reply.push_back(CH_EQ);
		for (int i = n - 1; i >= 0; i--)
			reply.push_back(digit_ch[i]);
		reply.push_back(CH_END);
		add_crlf();
	endfunction

	// Works out the characters caused by one accepted request.
	function void predict_request(logic kind, logic [7:0] b, logic [11:0] smp);
		bit done;
		reply.delete();
		if (kind == REQ_BYTE) begin
			done = parse_char(b);
			if (done && !awaiting_ok) begin
				if (head[0] == CH_R && head[1] == CH_S && head[2] == CH_T) begin
					held_sample = smp;
					add_crlf();
					add_frame();
					awaiting_ok = 1'b1;
					ticks_left = timeout_reg;
					rst_replies++;
				end
			end else if (done && head[0] == CH_O && head[1] == CH_K) begin
				add_crlf();
				awaiting_ok = 1'b0;
				ticks_left = '0;
			end
		end else if (ticks_left != 0) begin
			ticks_left = ticks_left - 1'b1;
			if (ticks_left == 0 && awaiting_ok) begin
				add_frame();
				ticks_left = timeout_reg;
				resends++;
			end
		end
		foreach (reply[i])
			tx_expect.push_back(tx_char_t'{ch: reply[i], last: (i == reply.size() - 1)});
	endfunction

	// Compare each transmitted character with the oldest expectation.
	always @(posedge clk) begin : check_tx
		tx_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_checked++;
			if (tx_expect.size() == 0) begin
				errors++;
				$display("%0t: unexpected character %h (last %b), nothing expected",
					$time, m_tdata, m_tlast);
			end else begin
				want = tx_expect.pop_front();
				if (m_tdata !== want.ch) begin
					errors++;
					$display("%0t: tx_byte expected %h, got %h", $time, want.ch, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last_byte expected %b, got %b", $time, want.last, m_tlast);
				end
			end
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_token != hold_done) begin
			hold_done = hold_token;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function logic [11:0] rand_sample();
		case ($urandom_range(9))
			0:       return 12'h000;
			1:       return 12'hFFF;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	// Any character other than the start and end marks.
	function logic [7:0] plain_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_START || b == CH_END);
		return b;
	endfunction

	function logic [7:0] garble_char();
		case ($urandom_range(6))
			0:       return CH_R;
			1:       return CH_S;
			2:       return CH_T;
			3:       return CH_O;
			4:       return CH_K;
			5:       return CH_START;
			default: return plain_char();
		endcase
	endfunction

	// Offers one request and predicts its result once it is accepted.
	task automatic send_request(input logic kind, input logic [7:0] b, input logic [11:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= TDATA_W'({smp, b});
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		predict_request(kind, b, smp);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(REQ_BYTE, b, rand_sample());
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, 8'($urandom_range(255)), rand_sample());
	endtask

	// Sends a string; the final character carries the given sample.
	task automatic send_text(input string txt, input logic [11:0] smp);
		for (int i = 0; i < txt.len(); i++)
			send_request(REQ_BYTE, txt[i], (i == txt.len() - 1) ? smp : rand_sample());
	endtask

	// Stops offering and waits until every predicted character has been seen.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tx_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		timeout_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A framed command, sometimes with filler that wraps the write position or a restart.
	task automatic send_command(input string word);
		int pick;
		int filler;
		send_byte(CH_START);
		pick = $urandom_range(99);
		filler = (pick < 70) ? 0 : (pick < 85) ? BUF_DEPTH_DEF : $urandom_range(1, 40);
		repeat (filler) send_byte(plain_char());
		if ($urandom_range(9) == 0)
			send_byte(CH_START);
		for (int i = 0; i < word.len(); i++)
			send_byte(word[i]);
		if ($urandom_range(3) == 0)
			send_byte(plain_char());
		send_byte(CH_END);
	endtask

	// A short broken command built from protocol letters and marks.
	task automatic send_garbled();
		send_byte(CH_START);
		repeat ($urandom_range(6)) send_byte(garble_char());
		if ($urandom_range(1) == 0)
			send_byte(CH_END);
	endtask

	task automatic random_traffic(input int goal);
		int stop_at;
		int pick;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 28)
				send_command("RST");
			else if (pick < 52)
				send_command("OK");
			else if (pick < 76)
				repeat ($urandom_range(1, 6)) send_tick();
			else if (pick < 86)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			else if (pick < 96)
				send_garbled();
			else
				wait_drained();
		end
	endtask

	// Bytes outside a command and a tick with the timer stopped produce nothing.
	task automatic test_idle_noise();
		send_request(REQ_BYTE, 8'hFF, 12'hFFF);
		send_tick();
		send_request(REQ_BYTE, 8'h00, 12'h000);
	endtask

	// A restart keeps the earlier head; the terminator clears the third entry.
	// OK while idle is ignored as well.
	task automatic test_head_rules();
		send_text("!RSTQ!RS#", rand_sample());
		send_text("!OK#", rand_sample());
	endtask

	task automatic test_rst_and_resend();
		write_timeout(16'd2);
		send_text("!X!RST#", 12'hFFF);
		send_tick();
		send_tick();
		send_text("!OK#", rand_sample());
	endtask

	// With a zero timeout the counter stays stopped and nothing is resent.
	task automatic test_zero_timeout();
		write_timeout(16'd0);
		send_text("!RST#", 12'h000);
		send_tick();
		send_tick();
		send_text("!OK#", rand_sample());
	endtask

	// Receiver holds off while ticks keep producing frames, so the input stalls;
	// the sender then pauses until the output has drained.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_timeout(16'd1);
		hold_token = hold_token + 1;
		send_text("!RST#", rand_sample());
		repeat (24) send_tick();
		send_text("!OK#", rand_sample());
		wait_drained();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct,
			input logic [TIMEOUT_W-1:0] timeout, input int goal);
		write_timeout(timeout);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		random_traffic(goal);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 37;
		recv_idle_pct = 50;

		test_idle_noise();
		test_head_rules();
		test_rst_and_resend();
		test_zero_timeout();
		test_random_phase(37, 50, 16'd3, 65);
		test_backpressure();
		test_random_phase(50, 37, 16'hFFFF, 65);
		test_random_phase(0, 0, 16'd5, 65);
		wait_drained();

		$display("Run sent %0d requests and checked %0d characters.", items_sent, chars_checked);
		$display("It saw %0d RST replies and %0d timeout resends, timeouts from 0 to 65535.",
			rst_replies, resends);
		if (errors == 0 && tx_expect.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
